### src/pidpc_pkg.sv
// ----------------------------------------------------------------------------
// pidpc_pkg
// Types and constants shared by the PID position controller.
// ----------------------------------------------------------------------------
package pidpc_pkg;

  // Configuration register map
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] CfgGainP     = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGainI     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgGainD     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIntWindow = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgDriveHigh = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgDriveLow  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgSettle    = 3'd6;

  localparam int CfgDataW = 16;

  // Register reset values (gains in Q8.8)
  localparam logic signed [15:0] GainPReset     = 16'sd151;
  localparam logic signed [15:0] GainIReset     = 16'sd23;
  localparam logic signed [15:0] GainDReset     = 16'sd0;
  localparam logic [15:0]        IntWindowReset = 16'd50;
  localparam logic [6:0]         DriveHighReset = 7'd127;
  localparam logic signed [7:0]  DriveLowReset  = -8'sd127;
  localparam logic [15:0]        SettleReset    = 16'd15;

  // One control tick
  typedef struct packed {
    logic               enable;
    logic signed [15:0] target;
    logic signed [15:0] sensor;
  } tick_t;

  // One drive result
  typedef struct packed {
    logic signed [7:0] drive;
    logic              moving;
  } result_t;

endpackage

### src/pid_position_controller.sv
// ----------------------------------------------------------------------------
// pid_position_controller
// PID position loop with an integral window, saturating integral and a
// clamped 8-bit drive output.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | direction | payload
//  ---------+----------------------------------+-----------+-----------------
//  tick     | tick_valid, tick_stall, tick     | request   | enable/target/sensor
//  result   | result_valid, result_stall, result | response | drive/moving
//  cfg      | cfg_we, cfg_index, cfg_data      | write     | 7 registers
//
//  A tick passes the input register, error/integral stage, multiplier
//  stage and sum/clamp result register. One tick is accepted every cycle
//  while tick_stall is low; the loop state (error_sum, previous_error,
//  moving_flag) updates once per tick, as the tick leaves stage 0.
//  Synchronous active-high reset clears the pipeline, error_sum and
//  previous_error, sets moving_flag and loads the register defaults.
//  A stalled result holds; tick_stall rises only once all stages are full.
// ----------------------------------------------------------------------------
module pid_position_controller (
  input  logic                                  clk,
  input  logic                                  rst,
  // tick requests
  input  logic                                  tick_valid,
  output logic                                  tick_stall,
  input  pidpc_pkg::tick_t                      tick,
  // results
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output pidpc_pkg::result_t                    result,
  // configuration
  input  logic                                  cfg_we,
  input  logic [pidpc_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [pidpc_pkg::CfgDataW-1:0]        cfg_data
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] gain_p;
  logic signed [15:0] gain_i;
  logic signed [15:0] gain_d;
  logic [15:0]        integral_window;
  logic [6:0]         drive_high;
  logic signed [7:0]  drive_low;
  logic [15:0]        settle_band;

  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p          <= pidpc_pkg::GainPReset;
      gain_i          <= pidpc_pkg::GainIReset;
      gain_d          <= pidpc_pkg::GainDReset;
      integral_window <= pidpc_pkg::IntWindowReset;
      drive_high      <= pidpc_pkg::DriveHighReset;
      drive_low       <= pidpc_pkg::DriveLowReset;
      settle_band     <= pidpc_pkg::SettleReset;
    end else if (cfg_we) begin
      case (cfg_index)
        pidpc_pkg::CfgGainP:     gain_p          <= cfg_data;
        pidpc_pkg::CfgGainI:     gain_i          <= cfg_data;
        pidpc_pkg::CfgGainD:     gain_d          <= cfg_data;
        pidpc_pkg::CfgIntWindow: integral_window <= cfg_data;
        pidpc_pkg::CfgDriveHigh: drive_high      <= cfg_data[6:0];
        pidpc_pkg::CfgDriveLow:  drive_low       <= cfg_data[7:0];
        pidpc_pkg::CfgSettle:    settle_band     <= cfg_data;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Pipeline flow control
  // --------------------------------------------------------------------------
  logic v0, v1, v2;
  logic rdy0, rdy1, rdy2, rdy_out;

  assign rdy_out    = !result_valid || !result_stall;
  assign rdy2       = !v2 || rdy_out;
  assign rdy1       = !v1 || rdy2;
  assign rdy0       = !v0 || rdy1;
  assign tick_stall = !rdy0;

  logic xfer0;  // stage 0 moves into stage 1, loop state updates
  assign xfer0 = v0 && rdy1;

  // --------------------------------------------------------------------------
  // Stage 0: input register
  // --------------------------------------------------------------------------
  pidpc_pkg::tick_t in_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (rdy0) begin
      v0 <= tick_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0 && tick_valid) begin
      in_reg <= tick;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 logic: error, window test, saturating integral, derivative
  // --------------------------------------------------------------------------
  logic signed [16:0] previous_error;
  logic signed [31:0] error_sum;
  logic               moving_flag;

  logic signed [16:0] err;
  logic [16:0]        amag;
  logic signed [32:0] sum_wide;
  logic signed [31:0] sum_sat;
  logic               integrate;
  logic signed [31:0] error_sum_next;
  logic signed [17:0] deriv;
  logic               moving_next;

  always_comb begin
    // encoder counts reversed, so error is the sum
    err  = 17'(in_reg.target) + 17'(in_reg.sensor);
    amag = err[16] ? (~err + 17'd1) : err;

    sum_wide = 33'(error_sum) + 33'(err);
    if (sum_wide[32] != sum_wide[31]) begin
      sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      sum_sat = sum_wide[31:0];
    end

    integrate      = (gain_i != 16'sd0) && (amag < {1'b0, integral_window});
    error_sum_next = (in_reg.enable && integrate) ? sum_sat : 32'sd0;

    deriv       = 18'(err) - 18'(previous_error);
    moving_next = in_reg.enable ? (amag >= {1'b0, settle_band}) : moving_flag;
  end

  // loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_error <= 17'sd0;
      error_sum      <= 32'sd0;
      moving_flag    <= 1'b1;
    end else if (xfer0) begin
      previous_error <= in_reg.enable ? err : 17'sd0;
      error_sum      <= error_sum_next;
      moving_flag    <= moving_next;
    end
  end

  // stage 1 registers
  logic               s1_enable;
  logic               s1_moving;
  logic signed [16:0] s1_err;
  logic signed [31:0] s1_sum;
  logic signed [17:0] s1_deriv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (rdy1) begin
      v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (xfer0) begin
      s1_enable <= in_reg.enable;
      s1_moving <= moving_next;
      s1_err    <= err;
      s1_sum    <= error_sum_next;
      s1_deriv  <= deriv;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: gain products
  // --------------------------------------------------------------------------
  logic               s2_enable;
  logic               s2_moving;
  logic signed [32:0] prod_p;
  logic signed [47:0] prod_i;
  logic signed [33:0] prod_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (rdy2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && rdy2) begin
      s2_enable <= s1_enable;
      s2_moving <= s1_moving;
      prod_p    <= 33'(gain_p) * 33'(s1_err);
      prod_i    <= 48'(gain_i) * 48'(s1_sum);
      prod_d    <= 34'(gain_d) * 34'(s1_deriv);
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: sum, truncate toward zero, clamp
  // --------------------------------------------------------------------------
  logic signed [49:0] acc;
  logic signed [41:0] q_floor;
  logic signed [41:0] q_trunc;
  logic signed [41:0] q_hi;
  logic signed [41:0] q_clamp;
  logic signed [41:0] lim_hi;
  logic signed [41:0] lim_lo;
  logic signed [7:0]  drive_next;

  always_comb begin
    acc     = 50'(prod_p) + 50'(prod_i) + 50'(prod_d);
    q_floor = 42'(acc >>> 8);
    // negative with a fraction: floor is one below truncation
    q_trunc = q_floor + 42'((acc[49] && (acc[7:0] != 8'd0)) ? 1 : 0);

    lim_hi = 42'($signed({1'b0, drive_high}));
    lim_lo = 42'(drive_low);
    // upper clamp first, lower clamp wins when the limits cross
    q_hi    = (q_trunc > lim_hi) ? lim_hi : q_trunc;
    q_clamp = (q_hi < lim_lo) ? lim_lo : q_hi;

    drive_next = s2_enable ? q_clamp[7:0] : 8'sd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (rdy_out) begin
      result_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && rdy_out) begin
      result.drive  <= drive_next;
      result.moving <= s2_moving;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // disabled tick clears the loop state
  assert property (@(posedge clk) disable iff (rst)
    (xfer0 && !in_reg.enable) |=> (error_sum == 32'sd0 && previous_error == 17'sd0))
    else $error("disabled tick did not clear loop state");

  // disabled tick holds the moving flag
  assert property (@(posedge clk) disable iff (rst)
    (xfer0 && !in_reg.enable) |=> (moving_flag == $past(moving_flag)))
    else $error("moving flag changed on disabled tick");

  // zero integral gain keeps the integral cleared
  assert property (@(posedge clk) disable iff (rst)
    (xfer0 && gain_i == 16'sd0) |=> (error_sum == 32'sd0))
    else $error("integral accumulated with zero gain");

  // loop state only moves when a tick leaves stage 0
  assert property (@(posedge clk) disable iff (rst)
    !xfer0 |=> ($stable(error_sum) && $stable(previous_error)))
    else $error("loop state changed without a tick");

  // a full, stalled pipeline must back-pressure the tick channel
  assert property (@(posedge clk) disable iff (rst)
    (v0 && v1 && v2 && result_valid && result_stall) |-> tick_stall)
    else $error("tick accepted into a full pipeline");

endmodule

### tb/pid_position_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_position_controller_tb
// Self-checking testbench for the PID position controller. Control ticks go
// in through the tick request channel while the register settings are
// changed between phases. Each accepted tick is run through a local copy of
// the control law (error, windowed saturating integral, derivative, Q8.8
// sum, truncation and clamps, moving flag), and every drive result is
// compared in order against it. Directed corner cases come first. They are
// followed by a full-rate integral run, a backpressure phase and
// randomized phases with bursty requests and receiver stalls.
// ----------------------------------------------------------------------------
module pid_position_controller_tb;

  // Index with no register behind it; writes to it must be dropped
  localparam logic [pidpc_pkg::CfgIdxW-1:0] CfgUnmapped = 3'd7;

  logic                             clk;
  logic                             rst;
  logic                             tick_valid;
  logic                             tick_stall;
  pidpc_pkg::tick_t                 tick;
  logic                             result_valid;
  logic                             result_stall;
  pidpc_pkg::result_t               result;
  logic                             cfg_we;
  logic [pidpc_pkg::CfgIdxW-1:0]    cfg_index;
  logic [pidpc_pkg::CfgDataW-1:0]   cfg_data;

  // Register shadow
  logic signed [15:0] gain_p, gain_i, gain_d;
  logic [15:0]        int_window, settle_band;
  logic [6:0]         drive_high;
  logic signed [7:0]  drive_low;

  // Loop state of the controller
  int prev_error;
  int error_sum;
  bit moving_flag;

  pidpc_pkg::result_t pending_drives[$];
  int                 mismatch_count = 0;

  // Receiver controls
  int hold_cycles = 0;
  bit rx_stalls   = 1'b1;

  pid_position_controller u_top (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .tick         (tick),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Control law for one tick; advances the loop state
  function automatic pidpc_pkg::result_t next_drive(pidpc_pkg::tick_t t);
    longint err, amag, sum, deriv, acc, q;
    pidpc_pkg::result_t r;
    r.drive = '0;
    if (t.enable) begin
      err  = longint'($signed(t.target)) + longint'($signed(t.sensor));
      amag = (err < 0) ? -err : err;
      if (gain_i != 0 && amag < longint'(int_window)) begin
        sum = longint'(error_sum) + err;
        if (sum > 64'sd2147483647) sum = 64'sd2147483647;
        if (sum < -64'sd2147483648) sum = -64'sd2147483648;
        error_sum = int'(sum);
      end else begin
        error_sum = 0;
      end
      deriv = err - longint'(prev_error);
      prev_error = int'(err);
      acc = longint'(gain_p) * err + longint'(gain_i) * longint'(error_sum)
          + longint'(gain_d) * deriv;
      // signed division truncates toward zero
      q = acc / 256;
      if (q > longint'(drive_high)) q = longint'(drive_high);
      if (q < longint'(drive_low)) q = longint'(drive_low);
      r.drive = q[7:0];
      moving_flag = (amag >= longint'(settle_band));
    end else begin
      prev_error = 0;
      error_sum  = 0;
    end
    r.moving = moving_flag;
    return r;
  endfunction

  function automatic pidpc_pkg::tick_t mk_tick(logic en, logic [15:0] tg, logic [15:0] sn);
    pidpc_pkg::tick_t t;
    t.enable = en;
    t.target = tg;
    t.sensor = sn;
    return t;
  endfunction

  function automatic pidpc_pkg::tick_t rand_tick();
    logic [15:0] corners[5] = '{16'h8000, 16'hFFFF, 16'h0000, 16'h0001, 16'h7FFF};
    int sel, tv, delta;
    pidpc_pkg::tick_t t;
    sel = $urandom_range(0, 19);
    t.enable = 1'b1;
    t.target = 16'($urandom);
    t.sensor = 16'($urandom);
    if (sel < 2) begin
      t.enable = 1'b0;
    end else if (sel < 12) begin
      // near balance, so the integral window and settle band come into play
      tv    = int'($urandom_range(0, 60000)) - 30000;
      delta = int'($urandom_range(0, 600)) - 300;
      t.target = 16'(tv);
      t.sensor = 16'(delta - tv);
    end else if (sel >= 17) begin
      t.target = corners[$urandom_range(0, 4)];
      t.sensor = corners[$urandom_range(0, 4)];
    end
    return t;
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'(int'($urandom_range(0, 1024)) - 512);
      2: return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_level();
    case ($urandom_range(0, 3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 400));
      2: return 16'hFFFF;
      default: return 16'h0000;
    endcase
  endfunction

  function automatic logic [15:0] rand_low();
    if ($urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(-int'($urandom_range(0, 127)));
  endfunction

  // Offer one request and hold it until accepted
  task automatic send_tick(pidpc_pkg::tick_t t);
    @(negedge clk);
    tick_valid = 1'b1;
    tick       = t;
    do @(posedge clk); while (tick_stall);
    pending_drives.push_back(next_drive(t));
  endtask

  task automatic sender_gap(int n);
    if (n > 0) begin
      @(negedge clk);
      tick_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    tick_valid = 1'b0;
    while (pending_drives.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [pidpc_pkg::CfgIdxW-1:0] idx,
                           logic [pidpc_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    case (idx)
      pidpc_pkg::CfgGainP:     gain_p      = data;
      pidpc_pkg::CfgGainI:     gain_i      = data;
      pidpc_pkg::CfgGainD:     gain_d      = data;
      pidpc_pkg::CfgIntWindow: int_window  = data;
      pidpc_pkg::CfgDriveHigh: drive_high  = data[6:0];
      pidpc_pkg::CfgDriveLow:  drive_low   = data[7:0];
      pidpc_pkg::CfgSettle:    settle_band = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_config(logic [15:0] gp, logic [15:0] gi, logic [15:0] gd,
                            logic [15:0] win, logic [15:0] hi, logic [15:0] lo,
                            logic [15:0] settle);
    write_reg(pidpc_pkg::CfgGainP, gp);
    write_reg(pidpc_pkg::CfgGainI, gi);
    write_reg(pidpc_pkg::CfgGainD, gd);
    write_reg(pidpc_pkg::CfgIntWindow, win);
    write_reg(pidpc_pkg::CfgDriveHigh, hi);
    write_reg(pidpc_pkg::CfgDriveLow, lo);
    write_reg(pidpc_pkg::CfgSettle, settle);
  endtask

  // Reset settings: settle band edge, disabled tick holding the flag, field extremes
  task automatic test_reset_defaults();
    send_tick(mk_tick(1'b1, 16'd10, 16'd5));
    send_tick(mk_tick(1'b1, 16'd3, 16'hFFFD));
    send_tick(mk_tick(1'b0, 16'h7FFF, 16'h7FFF));
    send_tick(mk_tick(1'b1, 16'hFFEC, 16'd6));
    send_tick(mk_tick(1'b1, 16'h7FFF, 16'h7FFF));
    send_tick(mk_tick(1'b1, 16'h8000, 16'h8000));
    send_tick(mk_tick(1'b1, 16'h7FFF, 16'h8000));
  endtask

  // Extreme gains and clamps, crossed clamps, unmapped index, window edges
  task automatic test_directed_limits();
    wait_drained();
    // upper bits of the clamp writes are junk and must be masked
    set_config(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 16'hFF7F, 16'h0080, 16'd0);
    send_tick(mk_tick(1'b1, 16'h7FFF, 16'h7FFF));
    send_tick(mk_tick(1'b1, 16'h8000, 16'h8000));
    send_tick(mk_tick(1'b1, 16'h0000, 16'h0000));
    send_tick(mk_tick(1'b1, 16'h0001, 16'h0000));
    send_tick(mk_tick(1'b1, 16'h0000, 16'hFFFF));

    // lower clamp above the upper one: the lower one wins
    wait_drained();
    set_config(16'h0100, 16'h8000, 16'h0000, 16'd1, 16'hAB05, 16'hAB10, 16'hFFFF);
    write_reg(CfgUnmapped, 16'h1234);
    send_tick(mk_tick(1'b1, 16'h0000, 16'h0000));
    send_tick(mk_tick(1'b1, 16'd3, 16'h0000));
    send_tick(mk_tick(1'b1, 16'hFF38, 16'h0000));

    // window and settle band on both sides of their edges
    wait_drained();
    set_config(16'h0001, 16'h7FFF, 16'h0000, 16'd100, 16'h007F, 16'hFF81, 16'd100);
    send_tick(mk_tick(1'b1, 16'd99, 16'h0000));
    send_tick(mk_tick(1'b1, 16'hFF9C, 16'h0000));
    send_tick(mk_tick(1'b1, 16'd50, 16'd50));
    send_tick(mk_tick(1'b1, 16'h0000, 16'hFF9D));
    send_tick(mk_tick(1'b0, 16'h0000, 16'h7FFF));
  endtask

  // Grow the integral with the largest errors at full rate, then reverse.
  // On the reversal tick the derivative term far outweighs the integral,
  // so the drive goes to the lower clamp.
  task automatic test_integral_run();
    int k;
    wait_drained();
    rx_stalls = 1'b0;
    set_config(16'h0000, 16'h0001, 16'h4000, 16'hFFFF, 16'h007F, 16'hFF81, 16'd100);
    for (k = 0; k < 20; k++) send_tick(mk_tick(1'b1, 16'h7FFF, 16'h7FFF));
    send_tick(mk_tick(1'b1, 16'h8000, 16'h8002));
    send_tick(mk_tick(1'b0, 16'h0000, 16'h0000));
    for (k = 0; k < 20; k++) send_tick(mk_tick(1'b1, 16'h8000, 16'h8002));
    send_tick(mk_tick(1'b1, 16'h7FFF, 16'h7FFF));
    wait_drained();
    rx_stalls = 1'b1;
  endtask

  // Long receiver hold while requests keep coming, then drain
  task automatic test_backpressure();
    int k;
    wait_drained();
    hold_cycles = 80;
    for (k = 0; k < 40; k++) send_tick(rand_tick());
    wait_drained();
  endtask

  // Random settings per phase, bursty requests
  task automatic test_random_ticks();
    int ph, n, burst_left;
    bit gappy;
    for (ph = 0; ph < 10; ph++) begin
      wait_drained();
      set_config(rand_gain(), rand_gain(), rand_gain(), rand_level(), 16'($urandom),
                 rand_low(), rand_level());
      gappy      = ($urandom_range(0, 3) != 0);
      rx_stalls  = ($urandom_range(0, 4) != 0);
      burst_left = 0;
      for (n = 0; n < 100; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (gappy) sender_gap($urandom_range(0, 6));
        end
        burst_left--;
        send_tick(rand_tick());
      end
    end
    rx_stalls = 1'b1;
  endtask

  // Receiver stall pattern: alternating runs, long free stretches, forced holds
  initial begin : rx_pattern
    int run_left;
    bit stall_phase;
    run_left     = 0;
    stall_phase  = 1'b0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        result_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        hold_cycles = 0;
      end
      if (run_left == 0) begin
        stall_phase = ~stall_phase;
        if (stall_phase) run_left = $urandom_range(1, 5);
        else if ($urandom_range(0, 4) == 0) run_left = $urandom_range(20, 40);
        else run_left = $urandom_range(1, 6);
      end
      run_left--;
      result_stall = rx_stalls && stall_phase;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    pidpc_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      if (pending_drives.size() == 0) begin
        $display("%0t: unexpected result: drive %0d moving %0b", $time,
                 result.drive, result.moving);
        mismatch_count++;
      end else begin
        want = pending_drives.pop_front();
        if (result.drive !== want.drive) begin
          $display("%0t: drive mismatch: expected %0d, actual %0d", $time,
                   want.drive, result.drive);
          mismatch_count++;
        end
        if (result.moving !== want.moving) begin
          $display("%0t: moving mismatch: expected %0b, actual %0b", $time,
                   want.moving, result.moving);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    rst        = 1'b1;
    tick_valid = 1'b0;
    tick       = '0;
    cfg_we     = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    gain_p      = pidpc_pkg::GainPReset;
    gain_i      = pidpc_pkg::GainIReset;
    gain_d      = pidpc_pkg::GainDReset;
    int_window  = pidpc_pkg::IntWindowReset;
    drive_high  = pidpc_pkg::DriveHighReset;
    drive_low   = pidpc_pkg::DriveLowReset;
    settle_band = pidpc_pkg::SettleReset;
    prev_error  = 0;
    error_sum   = 0;
    moving_flag = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_defaults();
    test_directed_limits();
    test_integral_run();
    test_backpressure();
    test_random_ticks();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
